// ----- src/ptd_pkg.sv -----
// Shared types and codes for the polygon-mode triangle decomposition block.
`timescale 1ns / 1ps
package ptd_pkg;

  localparam int COORD_BITS = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRONT_MODE  = 3'd0,
    CFG_BACK_MODE   = 3'd1,
    CFG_FRONT_CCW   = 3'd2,
    CFG_FACE_INVERT = 3'd3,
    CFG_FACE_ENABLE = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_POINT = 2'd2
  } fill_mode_t;

  typedef enum logic [1:0] {
    KIND_TRI     = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_POINT   = 2'd2,
    KIND_STIPPLE = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x0;
    logic signed [COORD_BITS-1:0] pos_y0;
    logic signed [COORD_BITS-1:0] pos_x1;
    logic signed [COORD_BITS-1:0] pos_y1;
    logic signed [COORD_BITS-1:0] pos_x2;
    logic signed [COORD_BITS-1:0] pos_y2;
    logic [2:0]                   prim_edge_flags;
    logic [2:0]                   vertex_edge_flags;
    logic                         stipple_clear;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] first_vertex;
    logic [1:0] second_vertex;
    logic       face_bit;
    logic       last_result;
  } out_t;

  // One queued result, face and last flag added at issue
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] first;
    logic [1:0] second;
  } item_t;

  // Orientation stage result handed to the emitter
  typedef struct packed {
    logic       neg;
    logic       zero;
    logic [2:0] en;
    logic       rs;
  } orient_t;

endpackage

// ----- src/ptd_orient.sv -----
// Three-stage pipeline computing the exact sign of the triangle area.
`timescale 1ns / 1ps
module ptd_orient (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  ptd_pkg::in_t    in_data,
  output logic            in_ready,
  output logic            res_valid,
  output ptd_pkg::orient_t res_data,
  input  logic            res_take
);
  import ptd_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // stage 1: edge differences
  logic                 v1_r;
  logic signed [DW-1:0] da_r, db_r, dc_r, dd_r;
  logic [2:0]           en1_r;
  logic                 rs1_r;
  // stage 2: cross products
  logic                 v2_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic [2:0]           en2_r;
  logic                 rs2_r;
  // stage 3: sign
  logic                 v3_r;
  orient_t              o3_r;

  logic rdy1, rdy2, rdy3;
  logic signed [DW-1:0] x0e, y0e, x1e, y1e, x2e, y2e;
  logic [PW:0]          diff;

  assign rdy3     = !v3_r || res_take;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign x0e = $signed({in_data.pos_x0[COORD_BITS-1], in_data.pos_x0});
  assign y0e = $signed({in_data.pos_y0[COORD_BITS-1], in_data.pos_y0});
  assign x1e = $signed({in_data.pos_x1[COORD_BITS-1], in_data.pos_x1});
  assign y1e = $signed({in_data.pos_y1[COORD_BITS-1], in_data.pos_y1});
  assign x2e = $signed({in_data.pos_x2[COORD_BITS-1], in_data.pos_x2});
  assign y2e = $signed({in_data.pos_y2[COORD_BITS-1], in_data.pos_y2});

  assign diff = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      da_r  <= x0e - x2e;
      db_r  <= y1e - y2e;
      dc_r  <= y0e - y2e;
      dd_r  <= x1e - x2e;
      en1_r <= in_data.prim_edge_flags & in_data.vertex_edge_flags;
      rs1_r <= in_data.stipple_clear;
    end
    if (rdy2) begin
      p1_r  <= da_r * db_r;
      p2_r  <= dc_r * dd_r;
      en2_r <= en1_r;
      rs2_r <= rs1_r;
    end
    if (rdy3) begin
      o3_r.neg  <= diff[PW];
      o3_r.zero <= (diff == '0);
      o3_r.en   <= en2_r;
      o3_r.rs   <= rs2_r;
    end
  end

  assign res_valid = v3_r;
  assign res_data  = o3_r;

endmodule

// ----- src/polygon_mode_triangle_decompose.sv -----
// Top level: polygon-mode triangle decomposition into fill, lines or points.
`timescale 1ns / 1ps
// A triangle transaction is taken at a clock edge with start high and busy low.
// The area sign is formed in a three-stage pipeline (edge differences,
// cross products, subtract), then a result emitter expands the triangle into
// 0..4 results and drives them one per cycle on out_result with out_valid.
// Each result is driven from the emitter's output register. A triangle
// occupies the single result port while its results are issued, or while it
// is loaded if it causes none, and the emitter loads the next triangle while
// it issues the last queued result; line mode with a stipple reset causes the
// most results. The receiver cannot stall: every result is valid for exactly
// one cycle. busy rises only when the emitter still holds two or more results
// and the pipeline behind it is full. Configuration writes are always ready
// and must be made only while no triangle is in flight.
module polygon_mode_triangle_decompose (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ptd_pkg::in_t                    in_data,
  output logic                            out_valid,
  output ptd_pkg::out_t                   out_result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptd_pkg::*;

  // configuration registers
  logic [1:0] front_mode_r, back_mode_r;
  logic       front_ccw_r, face_inv_r, face_en_r;

  // orientation pipeline
  logic    o_ready, o_valid, o_take;
  orient_t o_data;

  // emitter: up to four queued results
  item_t      list_r [4];
  item_t      list_nxt [4];
  logic [2:0] left_r, left_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       face_r, face_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;

  logic       load_ok, load;
  logic       front, face_calc;
  logic [1:0] mode;
  item_t      cand [4];
  logic [3:0] cv;
  item_t      build [4];
  logic [2:0] n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_mode_r <= MODE_FILL;
      back_mode_r  <= MODE_FILL;
      front_ccw_r  <= 1'b1;
      face_inv_r   <= 1'b0;
      face_en_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRONT_MODE:  front_mode_r <= cfg_data;
        CFG_BACK_MODE:   back_mode_r  <= cfg_data;
        CFG_FRONT_CCW:   front_ccw_r  <= cfg_data[0];
        CFG_FACE_INVERT: face_inv_r   <= cfg_data[0];
        CFG_FACE_ENABLE: face_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ptd_orient u_orient (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .in_ready  (o_ready),
    .res_valid (o_valid),
    .res_data  (o_data),
    .res_take  (o_take)
  );

  assign busy = !o_ready;

  // emitter takes a new triangle while it issues its last queued result
  assign load_ok = (left_r <= 3'd1);
  assign o_take  = o_valid && load_ok;
  assign load    = o_take;

  // face and mode selection; zero area counts as clockwise and never front
  always_comb begin
    if (front_ccw_r) begin
      front = o_data.neg;
      mode  = o_data.neg ? front_mode_r : back_mode_r;
    end else begin
      front = !o_data.neg && !o_data.zero;
      mode  = o_data.neg ? back_mode_r : front_mode_r;
    end
    face_calc = face_en_r && (front ^ face_inv_r);
  end

  // candidate results in issue order, then packed to the front
  always_comb begin
    for (int i = 0; i < 4; i++) cand[i] = '0;
    cv = '0;
    case (mode)
      MODE_LINE: begin
        cand[0] = '{kind: KIND_STIPPLE, first: 2'd0, second: 2'd0};
        cand[1] = '{kind: KIND_LINE,    first: 2'd2, second: 2'd0};
        cand[2] = '{kind: KIND_LINE,    first: 2'd0, second: 2'd1};
        cand[3] = '{kind: KIND_LINE,    first: 2'd1, second: 2'd2};
        cv      = {o_data.en[1], o_data.en[0], o_data.en[2], o_data.rs};
      end
      MODE_POINT: begin
        cand[0] = '{kind: KIND_POINT, first: 2'd0, second: 2'd0};
        cand[1] = '{kind: KIND_POINT, first: 2'd1, second: 2'd0};
        cand[2] = '{kind: KIND_POINT, first: 2'd2, second: 2'd0};
        cv      = {1'b0, o_data.en};
      end
      default: begin
        cand[0] = '{kind: KIND_TRI, first: 2'd0, second: 2'd0};
        cv      = 4'b0001;
      end
    endcase
    for (int i = 0; i < 4; i++) build[i] = '0;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        build[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) list_nxt[i] = list_r[i];
    left_nxt      = left_r;
    idx_nxt       = idx_r;
    face_nxt      = face_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (left_r != 3'd0) begin
      out_valid_nxt         = 1'b1;
      out_nxt.result_kind   = list_r[idx_r].kind;
      out_nxt.first_vertex  = list_r[idx_r].first;
      out_nxt.second_vertex = list_r[idx_r].second;
      out_nxt.face_bit      = face_r;
      out_nxt.last_result   = (left_r == 3'd1);
      left_nxt              = left_r - 3'd1;
      idx_nxt               = idx_r + 2'd1;
    end
    if (load) begin
      for (int i = 0; i < 4; i++) list_nxt[i] = build[i];
      left_nxt = n;
      idx_nxt  = '0;
      face_nxt = face_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) list_r[i] <= list_nxt[i];
    idx_r  <= idx_nxt;
    face_r <= face_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef NO_ASSERTIONS
  // busy only when the emitter is backed up behind a full pipeline
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (o_valid && (left_r > 3'd1)))
    else $error("busy without a backed-up emitter");

  // a result that is not the last is always followed by another
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last_result) |=> out_valid_r)
    else $error("result burst broken before last result");

  // a triangle pass is always the only result of its transaction
  a_tri_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.result_kind == KIND_TRI)) |-> out_r.last_result)
    else $error("triangle pass not marked last");

  // queue never holds more than four results
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 3'd4)
    else $error("emitter count out of range");
`endif

endmodule

// ----- verif/tb_polygon_mode_triangle_decompose.sv -----
// Testbench for polygon_mode_triangle_decompose: random and directed triangles, scoreboard check.
`timescale 1ns / 1ps
module tb_polygon_mode_triangle_decompose;
  import ptd_pkg::*;

  // Coordinate extremes and spare codes that the package does not name
  localparam int C_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_BITS - 1));
  localparam logic [1:0] MODE_SPARE = 2'd3;        // undefined mode, behaves as fill
  localparam int CFG_IDX_TOP = (1 << CFG_IDX_W) - 1; // highest (unused) register index

  // Settle time after the last result, long enough to flush a triangle with no results
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_SHOWN = 10;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 55;

  // Scoreboard: own copy of the mode registers, expands each accepted triangle
  // into the results it must cause and checks the output stream in order.
  class decomp_scoreboard;
    logic [1:0] front_mode, back_mode;
    logic ccw_front, invert_face, enable_face;
    out_t expected_q[$];
    int n_tris, n_fail;
    int kind_seen[4];

    function new();
      front_mode = MODE_FILL;
      back_mode = MODE_FILL;
      ccw_front = 1'b1;
      invert_face = 1'b0;
      enable_face = 1'b0;
      n_tris = 0;
      n_fail = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRONT_MODE: front_mode = val;
        CFG_BACK_MODE: back_mode = val;
        CFG_FRONT_CCW: ccw_front = val[0];
        CFG_FACE_INVERT: invert_face = val[0];
        CFG_FACE_ENABLE: enable_face = val[0];
        default: ;
      endcase
    endfunction

    function longint widen(logic signed [COORD_BITS-1:0] v);
      return v;
    endfunction

    function out_t make_res(kind_t k, logic [1:0] a, logic [1:0] b, logic f);
      out_t r;
      r.result_kind = k;
      r.first_vertex = a;
      r.second_vertex = b;
      r.face_bit = f;
      r.last_result = 1'b0;
      return r;
    endfunction

    function void note_triangle(in_t t);
      longint ax, ay, bx, by, area;
      logic front, ccw, face;
      logic [1:0] mode;
      logic [2:0] en;
      out_t batch[$];
      out_t tail;
      // exact area sign: 25-bit deltas, 50-bit products fit easily in 64 bits
      ax = widen(t.pos_x0) - widen(t.pos_x2);
      ay = widen(t.pos_y0) - widen(t.pos_y2);
      bx = widen(t.pos_x1) - widen(t.pos_x2);
      by = widen(t.pos_y1) - widen(t.pos_y2);
      area = ax * by - ay * bx;
      ccw = (area < 0);
      // zero area is never front, for either winding
      front = ccw_front ? (area < 0) : (area > 0);
      face = enable_face ? (front ^ invert_face) : 1'b0;
      mode = (ccw == ccw_front) ? front_mode : back_mode;
      en = t.prim_edge_flags & t.vertex_edge_flags;
      case (mode)
        MODE_LINE: begin
          if (t.stipple_clear) batch.push_back(make_res(KIND_STIPPLE, 2'd0, 2'd0, face));
          if (en[2]) batch.push_back(make_res(KIND_LINE, 2'd2, 2'd0, face));
          if (en[0]) batch.push_back(make_res(KIND_LINE, 2'd0, 2'd1, face));
          if (en[1]) batch.push_back(make_res(KIND_LINE, 2'd1, 2'd2, face));
        end
        MODE_POINT: begin
          if (en[0]) batch.push_back(make_res(KIND_POINT, 2'd0, 2'd0, face));
          if (en[1]) batch.push_back(make_res(KIND_POINT, 2'd1, 2'd0, face));
          if (en[2]) batch.push_back(make_res(KIND_POINT, 2'd2, 2'd0, face));
        end
        default: batch.push_back(make_res(KIND_TRI, 2'd0, 2'd0, face));
      endcase
      if (batch.size() > 0) begin
        tail = batch.pop_back();
        tail.last_result = 1'b1;
        batch.push_back(tail);
      end
      foreach (batch[i]) begin
        expected_q.push_back(batch[i]);
        kind_seen[batch[i].result_kind]++;
      end
      n_tris++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_SHOWN)
          $display("%0t: result with nothing pending: kind %0d v%0d/v%0d face %0d last %0d",
                   $time, got.result_kind, got.first_vertex, got.second_vertex,
                   got.face_bit, got.last_result);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind || got.first_vertex !== want.first_vertex ||
          got.second_vertex !== want.second_vertex || got.face_bit !== want.face_bit ||
          got.last_result !== want.last_result) begin
        n_fail++;
        if (n_fail <= MAX_SHOWN) begin
          $write("%0t: mismatch: expected kind %0d v%0d/v%0d face %0d last %0d, ",
                 $time, want.result_kind, want.first_vertex, want.second_vertex,
                 want.face_bit, want.last_result);
          $display("got kind %0d v%0d/v%0d face %0d last %0d",
                   got.result_kind, got.first_vertex, got.second_vertex,
                   got.face_bit, got.last_result);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close();
      if (expected_q.size() != 0) begin
        $display("%0d expected results never arrived", expected_q.size());
        n_fail += expected_q.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  decomp_scoreboard sb = new();
  int n_settings = 0;

  polygon_mode_triangle_decompose uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_result(out_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: all sampling happens at the rising edge, before the block's
  // nonblocking updates land, so the values seen are those of the ending cycle.
  // A triangle taken at this edge cannot produce a result at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_triangle(in_data);
      if (out_valid) sb.check_result(out_result);
    end
  end

  // Build one triangle transaction; coordinates wrap to the port width
  function automatic in_t mk_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                 logic [2:0] pf, logic [2:0] vf, logic rs);
    in_t t;
    t.pos_x0 = x0[COORD_BITS-1:0];
    t.pos_y0 = y0[COORD_BITS-1:0];
    t.pos_x1 = x1[COORD_BITS-1:0];
    t.pos_y1 = y1[COORD_BITS-1:0];
    t.pos_x2 = x2[COORD_BITS-1:0];
    t.pos_y2 = y2[COORD_BITS-1:0];
    t.prim_edge_flags = pf;
    t.vertex_edge_flags = vf;
    t.stipple_clear = rs;
    return t;
  endfunction

  // Random triangle: a mix of full-range, tiny, extreme, collinear and
  // small-but-far-out shapes, so both windings and zero area keep showing up.
  function automatic in_t rand_tri();
    int c[6];
    int bx, by, dx, dy, k1, k2;
    logic [2:0] vf;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: foreach (c[j]) c[j] = $urandom();
      4, 5: foreach (c[j]) c[j] = int'($urandom_range(0, 4095)) - 2048;
      6: foreach (c[j]) begin
        case ($urandom_range(0, 4))
          0: c[j] = C_MAX;
          1: c[j] = C_MIN;
          2: c[j] = 0;
          3: c[j] = -1;
          default: c[j] = 1;
        endcase
      end
      7: begin
        // three points on one line (or repeated points): exact zero area
        bx = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        by = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        dx = int'($urandom_range(0, 2047)) - 1024;
        dy = int'($urandom_range(0, 2047)) - 1024;
        k1 = int'($urandom_range(0, 16)) - 8;
        k2 = int'($urandom_range(0, 16)) - 8;
        c = '{bx, by, bx + k1 * dx, by + k1 * dy, bx + k2 * dx, by + k2 * dy};
      end
      default: begin
        bx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        by = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        for (int j = 0; j < 6; j += 2) begin
          c[j] = bx + int'($urandom_range(0, 512)) - 256;
          c[j+1] = by + int'($urandom_range(0, 512)) - 256;
        end
      end
    endcase
    // vertex flags lean toward all-set so most edges survive the AND
    vf = ($urandom_range(0, 1) == 1) ? 3'b111 : 3'($urandom_range(0, 7));
    return mk_tri(c[0], c[1], c[2], c[3], c[4], c[5], 3'($urandom_range(0, 7)), vf,
                  1'($urandom_range(0, 1)));
  endfunction

  // Holds start high until the triangle is taken; the caller lowers start
  // only when it chooses to idle, so start never dips between items.
  task automatic send_tri(input in_t t);
    in_data <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // One full register setting, optionally with a write to an unused index
  task automatic program_regs(input logic [1:0] fm, input logic [1:0] bm,
                              input logic [1:0] ccw_v, input logic [1:0] inv_v,
                              input logic [1:0] en_v, input bit poke_spare);
    write_cfg(CFG_FRONT_MODE, fm);
    write_cfg(CFG_BACK_MODE, bm);
    write_cfg(CFG_FRONT_CCW, ccw_v);
    write_cfg(CFG_FACE_INVERT, inv_v);
    write_cfg(CFG_FACE_ENABLE, en_v);
    if (poke_spare)
      write_cfg(CFG_IDX_W'($urandom_range(CFG_FACE_ENABLE + 1, CFG_IDX_TOP)),
                CFG_DATA_W'($urandom_range(0, 3)));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Block is idle once every expected result came and the pipeline flushed
  // any triangle that produces nothing
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int guard;
    bit gappy;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ccw front in line mode, cw back in point mode, face visible
    program_regs(MODE_LINE, MODE_POINT, 2'd1, 2'd0, 2'd1, 1'b0);
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b111, 3'b111, 1'b1));     // all four results
    send_tri(mk_tri(256, 0, 0, 256, 0, 0, 3'b111, 3'b111, 1'b0));     // three points
    send_tri(mk_tri(100, 100, 100, 100, 100, 100, 3'b111, 3'b111, 1'b1)); // zero area
    send_tri(mk_tri(C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 3'b111, 3'b111, 1'b1)); // collinear, wide
    send_tri(mk_tri(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(C_MIN, C_MIN, C_MAX, C_MAX, 0, 1, 3'b111, 3'b111, 1'b1));  // barely off line
    send_tri(mk_tri(C_MIN, C_MIN, C_MAX, C_MAX, 0, -1, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b000, 3'b111, 1'b0));     // line, nothing flagged
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b111, 3'b000, 1'b1));     // stipple reset only
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b101, 3'b011, 1'b0));     // single edge
    send_tri(mk_tri(256, 0, 0, 256, 0, 0, 3'b110, 3'b111, 1'b1));     // two points
    send_tri(mk_tri(256, 0, 0, 256, 0, 0, 3'b111, 3'b000, 1'b1));     // point, nothing flagged
    start <= 1'b0;
    wait_idle();

    // Directed: cw is front now, face inverted
    program_regs(MODE_POINT, MODE_LINE, 2'd0, 2'd1, 2'd1, 1'b0);
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(256, 0, 0, 256, 0, 0, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(-5, 7, -5, 7, 9, 9, 3'b111, 3'b111, 1'b1));       // zero area
    send_tri(mk_tri(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 3'b111, 3'b111, 1'b1));
    start <= 1'b0;
    wait_idle();

    // Directed: undefined mode code on both windings acts as fill, face gated off
    program_regs(MODE_SPARE, MODE_SPARE, 2'd1, 2'd1, 2'd0, 1'b1);
    send_tri(mk_tri(0, 256, 256, 0, 0, 0, 3'b111, 3'b111, 1'b1));
    send_tri(mk_tri(256, 0, 0, 256, 0, 0, 3'b000, 3'b000, 1'b0));
    send_tri(mk_tri(3, 3, 3, 3, 3, 3, 3'b111, 3'b111, 1'b1));
    start <= 1'b0;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_regs(MODE_LINE, MODE_LINE, 2'($urandom_range(0, 3)),
                        2'($urandom_range(0, 3)), 2'd1, 1'b0);
        1: program_regs(MODE_POINT, MODE_POINT, 2'($urandom_range(0, 3)),
                        2'($urandom_range(0, 3)), 2'd1, 1'b1);
        2: program_regs(MODE_SPARE, MODE_LINE, 2'd3, 2'd3, 2'd3, 1'b0);
        default: program_regs(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), $urandom_range(0, 2) == 0);
      endcase
      // phase 2 and the final phase run back to back to keep busy asserted
      gappy = !(ph == 2 || ph == N_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_tri(rand_tri());
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          // hold the sender off until the output side has fully caught up
          start <= 1'b0;
          wait_idle();
        end else if (gappy && $urandom_range(0, 9) < 3) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
      start <= 1'b0;
    end

    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close();

    $write("Ran %0d triangles under %0d register settings: ", sb.n_tris, n_settings);
    $display("%0d passes, %0d lines, %0d points, %0d stipple resets",
             sb.kind_seen[KIND_TRI], sb.kind_seen[KIND_LINE],
             sb.kind_seen[KIND_POINT], sb.kind_seen[KIND_STIPPLE]);
    $display("Failures counted: %0d", sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("[polygon_mode_triangle_decompose] OK");
    end else begin
      $display("[polygon_mode_triangle_decompose] ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Timeout");
    $display("[polygon_mode_triangle_decompose] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ptd_pkg.sv
src/ptd_orient.sv
src/polygon_mode_triangle_decompose.sv
verif/tb_polygon_mode_triangle_decompose.sv
